[hdl/cmt_pkg.sv]
// Shared types and codes for the channel mailbox table.
package cmt_pkg;

	localparam int CHANNEL_BASE = 500;
	localparam int LEN_W = 7;

	localparam logic [1:0] OP_OPEN       = 2'd0;
	localparam logic [1:0] OP_SEND_BEGIN = 2'd1;
	localparam logic [1:0] OP_SEND_DATA  = 2'd2;
	localparam logic [1:0] OP_RECEIVE    = 2'd3;

	localparam logic [3:0] ST_OK         = 4'd0;
	localparam logic [3:0] ST_FULL       = 4'd1;
	localparam logic [3:0] ST_TOO_LONG   = 4'd2;
	localparam logic [3:0] ST_RATE       = 4'd3;
	localparam logic [3:0] ST_NO_CHANNEL = 4'd4;
	localparam logic [3:0] ST_BUSY       = 4'd5;
	localparam logic [3:0] ST_ACCESS     = 4'd6;
	localparam logic [3:0] ST_EMPTY      = 4'd7;
	localparam logic [3:0] ST_UNEXPECTED = 4'd8;
	localparam logic [3:0] ST_LOADING    = 4'd9;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] chan_ref;
		logic [31:0] pid;
		logic [31:0] peer_pid;
		logic [15:0] length;
		logic        rate_ok;
		logic        access_ok;
		logic [7:0]  data_byte;
	} req_t;

	typedef struct packed {
		logic [3:0] status;
		logic [9:0] channel_out;
		logic       data_valid;
		logic [7:0] data_out;
		logic       last;
	} rsp_t;

	typedef struct packed {
		logic [31:0]      src;
		logic [31:0]      dst;
		logic [LEN_W-1:0] len;
	} chan_entry_t;

endpackage

[hdl/cmt_table_ram.sv]
// Channel table memory: source, destination and message length per channel.
module cmt_table_ram #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  cmt_pkg::chan_entry_t  wdata,
	input  logic [AW-1:0]         raddr,
	output cmt_pkg::chan_entry_t  rdata
);

	cmt_pkg::chan_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/cmt_payload_ram.sv]
// Payload byte memory, one slot of bytes per channel.
module cmt_payload_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[hdl/cmt_ctrl.sv]
// Sequencer: checks commands, updates channel state and streams received bytes.
module cmt_ctrl #(
	parameter int MAX_CHANNELS  = 16,
	parameter int PAYLOAD_BYTES = 64,
	parameter int IW            = 4,
	parameter int CW            = 5,
	parameter int AW            = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  cmt_pkg::req_t        request,
	output logic                 response_valid,
	output cmt_pkg::rsp_t        response,
	output logic                 tbl_we,
	output logic [IW-1:0]        tbl_waddr,
	output cmt_pkg::chan_entry_t tbl_wdata,
	output logic [IW-1:0]        tbl_raddr,
	input  cmt_pkg::chan_entry_t tbl_rdata,
	output logic                 pay_we,
	output logic [AW-1:0]        pay_waddr,
	output logic [7:0]           pay_wdata,
	output logic [AW-1:0]        pay_raddr,
	input  logic [7:0]           pay_rdata
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_EXEC   = 2'd1;
	localparam logic [1:0] S_STREAM = 2'd2;

	localparam int LW = cmt_pkg::LEN_W;

	logic [1:0]          state_q, state_d;
	cmt_pkg::req_t       req_q;
	logic [CW-1:0]       open_cnt_q;
	logic [MAX_CHANNELS-1:0] waiting_q;
	logic                load_active_q;
	logic [IW-1:0]       load_ch_q;
	logic [LW-1:0]       load_rem_q;
	logic [LW-1:0]       load_pos_q;
	logic [IW-1:0]       sidx_q;
	logic [LW-1:0]       pos_q;
	logic [LW-1:0]       n_q;
	cmt_pkg::rsp_t       rsp_q, rsp_d;
	logic                rsp_v_q, rsp_v_d;

	logic [31:0]         chan_off;
	logic [IW-1:0]       idx;
	logic                hit;
	logic [LW-1:0]       rx_n;
	logic                wait_we, wait_val;
	logic [IW-1:0]       wait_idx;
	logic                open_inc, load_start, load_step, stream_go;
	logic [IW-1:0]       ridx;
	logic [LW-1:0]       rpos;

	assign chan_off  = req_q.chan_ref - 32'(cmt_pkg::CHANNEL_BASE);
	assign idx       = chan_off[IW-1:0];
	assign hit       = (req_q.chan_ref >= 32'(cmt_pkg::CHANNEL_BASE))
		&& (chan_off < 32'(open_cnt_q));
	assign rx_n      = (16'(tbl_rdata.len) < req_q.length) ? tbl_rdata.len
		: req_q.length[LW-1:0];
	assign tbl_raddr = IW'(request.chan_ref - 32'(cmt_pkg::CHANNEL_BASE));

	assign pay_wdata = req_q.data_byte;
	assign pay_waddr = AW'(load_ch_q) * AW'(PAYLOAD_BYTES) + AW'(load_pos_q);
	assign ridx      = (state_q == S_EXEC) ? idx : sidx_q;
	assign rpos      = (state_q == S_EXEC) ? '0 : pos_q + LW'(1);
	assign pay_raddr = AW'(ridx) * AW'(PAYLOAD_BYTES) + AW'(rpos);

	always_comb begin
		state_d    = state_q;
		rsp_d      = '0;
		rsp_d.last = 1'b1;
		rsp_v_d    = 1'b0;
		tbl_we     = 1'b0;
		tbl_waddr  = idx;
		tbl_wdata  = tbl_rdata;
		pay_we     = 1'b0;
		wait_we    = 1'b0;
		wait_val   = 1'b0;
		wait_idx   = idx;
		open_inc   = 1'b0;
		load_start = 1'b0;
		load_step  = 1'b0;
		stream_go  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_IDLE;
				rsp_v_d = 1'b1;
				if (req_q.operation == cmt_pkg::OP_SEND_DATA) begin
					if (!load_active_q) begin
						rsp_d.status = cmt_pkg::ST_UNEXPECTED;
					end else begin
						pay_we    = 1'b1;
						load_step = 1'b1;
						if (load_rem_q == LW'(1)) begin
							wait_we  = 1'b1;
							wait_val = 1'b1;
							wait_idx = load_ch_q;
						end
					end
				end else if (load_active_q) begin
					rsp_d.status = cmt_pkg::ST_LOADING;
				end else begin
					case (req_q.operation)
						cmt_pkg::OP_OPEN: begin
							if (open_cnt_q == CW'(MAX_CHANNELS)) begin
								rsp_d.status = cmt_pkg::ST_FULL;
							end else begin
								tbl_we            = 1'b1;
								tbl_waddr         = open_cnt_q[IW-1:0];
								tbl_wdata.src     = req_q.pid;
								tbl_wdata.dst     = req_q.peer_pid;
								tbl_wdata.len     = '0;
								wait_we           = 1'b1;
								wait_idx          = open_cnt_q[IW-1:0];
								open_inc          = 1'b1;
								rsp_d.channel_out = 10'(open_cnt_q)
									+ 10'(cmt_pkg::CHANNEL_BASE);
							end
						end
						cmt_pkg::OP_SEND_BEGIN: begin
							if (req_q.length > 16'(PAYLOAD_BYTES)) begin
								rsp_d.status = cmt_pkg::ST_TOO_LONG;
							end else if (!req_q.rate_ok) begin
								rsp_d.status = cmt_pkg::ST_RATE;
							end else if (!hit || tbl_rdata.src != req_q.pid) begin
								rsp_d.status = cmt_pkg::ST_NO_CHANNEL;
							end else if (waiting_q[idx]) begin
								rsp_d.status = cmt_pkg::ST_BUSY;
							end else if (!req_q.access_ok) begin
								rsp_d.status = cmt_pkg::ST_ACCESS;
							end else begin
								tbl_we        = 1'b1;
								tbl_wdata.len = req_q.length[LW-1:0];
								if (req_q.length == 16'd0) begin
									wait_we  = 1'b1;
									wait_val = 1'b1;
								end else begin
									load_start = 1'b1;
								end
							end
						end
						cmt_pkg::OP_RECEIVE: begin
							if (!hit || tbl_rdata.dst != req_q.pid) begin
								rsp_d.status = cmt_pkg::ST_NO_CHANNEL;
							end else if (!waiting_q[idx]) begin
								rsp_d.status = cmt_pkg::ST_EMPTY;
							end else if (!req_q.access_ok) begin
								rsp_d.status = cmt_pkg::ST_ACCESS;
							end else begin
								wait_we = 1'b1;
								if (rx_n != '0) begin
									rsp_v_d   = 1'b0;
									stream_go = 1'b1;
									state_d   = S_STREAM;
								end
							end
						end
						default: begin
							rsp_d.status = cmt_pkg::ST_UNEXPECTED;
						end
					endcase
				end
			end
			S_STREAM: begin
				rsp_v_d          = 1'b1;
				rsp_d.data_valid = 1'b1;
				rsp_d.data_out   = pay_rdata;
				rsp_d.last       = (pos_q + LW'(1) == n_q);
				if (rsp_d.last) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			open_cnt_q    <= '0;
			waiting_q     <= '0;
			load_active_q <= 1'b0;
			load_ch_q     <= '0;
			load_rem_q    <= '0;
			load_pos_q    <= '0;
			rsp_v_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			rsp_v_q <= rsp_v_d;
			if (open_inc) begin
				open_cnt_q <= open_cnt_q + CW'(1);
			end
			if (wait_we) begin
				waiting_q[wait_idx] <= wait_val;
			end
			if (load_start) begin
				load_active_q <= 1'b1;
				load_ch_q     <= idx;
				load_rem_q    <= req_q.length[LW-1:0];
				load_pos_q    <= '0;
			end else if (load_step) begin
				load_rem_q <= load_rem_q - LW'(1);
				load_pos_q <= load_pos_q + LW'(1);
				if (load_rem_q == LW'(1)) begin
					load_active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		rsp_q <= rsp_d;
		if (state_q == S_IDLE && start) begin
			req_q <= request;
		end
		if (stream_go) begin
			sidx_q <= idx;
			n_q    <= rx_n;
			pos_q  <= '0;
		end else if (state_q == S_STREAM) begin
			pos_q <= pos_q + LW'(1);
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign response       = rsp_q;
	assign response_valid = rsp_v_q;

endmodule

[hdl/channel_mailbox_table.sv]
// Top level of the channel mailbox table.
//
// Commands enter on request and are taken at a rising edge with start high
// and busy low. Operations: open a channel, begin a send, load one send byte,
// receive. Every command returns results on response, each marked by
// response_valid high for a single cycle, a receive's bytes back to back;
// the receiver takes them as they come and cannot hold them off.
// Channel records sit in a small synchronous table memory read when the
// command is taken; payload bytes sit in a second memory, one slot of
// PAYLOAD_BYTES per channel.
// Open, send and send byte commands pass through the table read, then the
// check and write back. Their single result appears the cycle after, while
// the next command may already be taken. A receive keeps busy high while it
// reads its bytes and streams one byte per cycle from the payload memory read
// port, last set on the final byte.
// Reset empties the table, clears all waiting marks and ends any send being
// loaded; no clearing pass is needed.
module channel_mailbox_table #(
	parameter int MAX_CHANNELS  = 16,
	parameter int PAYLOAD_BYTES = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  cmt_pkg::req_t request,
	output logic          response_valid,
	output cmt_pkg::rsp_t response
);

	localparam int IW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CW    = $clog2(MAX_CHANNELS + 1);
	localparam int PDEP  = MAX_CHANNELS * PAYLOAD_BYTES;
	localparam int AW    = (PDEP > 1) ? $clog2(PDEP) : 1;

	logic                 tbl_we;
	logic [IW-1:0]        tbl_waddr;
	cmt_pkg::chan_entry_t tbl_wdata;
	logic [IW-1:0]        tbl_raddr;
	cmt_pkg::chan_entry_t tbl_rdata;
	logic                 pay_we;
	logic [AW-1:0]        pay_waddr;
	logic [7:0]           pay_wdata;
	logic [AW-1:0]        pay_raddr;
	logic [7:0]           pay_rdata;

	cmt_ctrl #(
		.MAX_CHANNELS  (MAX_CHANNELS),
		.PAYLOAD_BYTES (PAYLOAD_BYTES),
		.IW            (IW),
		.CW            (CW),
		.AW            (AW)
	) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.request        (request),
		.response_valid (response_valid),
		.response       (response),
		.tbl_we         (tbl_we),
		.tbl_waddr      (tbl_waddr),
		.tbl_wdata      (tbl_wdata),
		.tbl_raddr      (tbl_raddr),
		.tbl_rdata      (tbl_rdata),
		.pay_we         (pay_we),
		.pay_waddr      (pay_waddr),
		.pay_wdata      (pay_wdata),
		.pay_raddr      (pay_raddr),
		.pay_rdata      (pay_rdata)
	);

	cmt_table_ram #(
		.DEPTH (MAX_CHANNELS),
		.AW    (IW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.raddr (tbl_raddr),
		.rdata (tbl_rdata)
	);

	cmt_payload_ram #(
		.DEPTH (PDEP),
		.AW    (AW)
	) u_payload (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.raddr (pay_raddr),
		.rdata (pay_rdata)
	);

`ifndef SYNTHESIS
	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("item taken but block not busy");

	a_rsp_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		response_valid |-> $past(busy))
		else $error("result without preceding work");

	a_stream_cont: assert property (@(posedge clk) disable iff (!arst_n)
		response_valid && !response.last |=> response_valid)
		else $error("byte stream broken before last");

	a_data_ok: assert property (@(posedge clk) disable iff (!arst_n)
		response_valid && response.data_valid |-> response.status == cmt_pkg::ST_OK)
		else $error("data byte with error status");
`endif

endmodule

[tb/sv/channel_mailbox_table_test.sv]
// Self-checking testbench for the channel mailbox table: directed and random commands.
`timescale 1ns / 100ps

module channel_mailbox_table_test;

	localparam int NUM_CHAN  = 16;
	localparam int SLOT_SIZE = 64;
	localparam int N_RANDOM  = 325;

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmt_pkg::req_t cmd = '0;
	logic busy;
	logic resp_valid;
	cmt_pkg::rsp_t resp;

	channel_mailbox_table #(
		.MAX_CHANNELS(NUM_CHAN),
		.PAYLOAD_BYTES(SLOT_SIZE)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(cmd),
		.response_valid(resp_valid),
		.response(resp)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// predicted table state
	logic [4:0]  open_cnt = '0;
	logic [31:0] src_pid [NUM_CHAN];
	logic [31:0] dst_pid [NUM_CHAN];
	logic        waiting [NUM_CHAN];
	logic [6:0]  msg_len [NUM_CHAN];
	logic [7:0]  slot_bytes [NUM_CHAN][SLOT_SIZE];
	logic        loading = 1'b0;
	logic [3:0]  load_ch = '0;
	logic [6:0]  load_left = '0;
	logic [6:0]  load_pos = '0;

	cmt_pkg::req_t pending [$];
	cmt_pkg::rsp_t due_replies [$];
	int   n_issued = 0;
	int   n_accepted = 0;
	int   n_replies = 0;
	int   n_bytes = 0;
	int   errors = 0;
	logic taken = 1'b0;
	int   gap = 0;
	logic burst = 1'b0;

	initial begin
		for (int i = 0; i < NUM_CHAN; i++)
			waiting[i] = 1'b0;
	end

	function automatic cmt_pkg::rsp_t mk_rsp(input logic [3:0] st, input logic [9:0] ch,
			input logic dv, input logic [7:0] d, input logic lst);
		cmt_pkg::rsp_t r;
		r.status = st;
		r.channel_out = ch;
		r.data_valid = dv;
		r.data_out = d;
		r.last = lst;
		return r;
	endfunction

	task automatic compute_replies(input cmt_pkg::req_t r);
		int idx;
		int n;
		idx = -1;
		if (r.chan_ref >= cmt_pkg::CHANNEL_BASE &&
				r.chan_ref - cmt_pkg::CHANNEL_BASE < open_cnt)
			idx = int'(r.chan_ref - cmt_pkg::CHANNEL_BASE);
		if (r.operation == cmt_pkg::OP_SEND_DATA) begin
			if (!loading) begin
				due_replies.push_back(mk_rsp(cmt_pkg::ST_UNEXPECTED, '0, 1'b0, '0, 1'b1));
			end else begin
				slot_bytes[load_ch][load_pos] = r.data_byte;
				load_pos++;
				load_left--;
				if (load_left == 0) begin
					waiting[load_ch] = 1'b1;
					loading = 1'b0;
				end
				due_replies.push_back(mk_rsp(cmt_pkg::ST_OK, '0, 1'b0, '0, 1'b1));
			end
		end else if (loading) begin
			due_replies.push_back(mk_rsp(cmt_pkg::ST_LOADING, '0, 1'b0, '0, 1'b1));
		end else if (r.operation == cmt_pkg::OP_OPEN) begin
			if (open_cnt >= NUM_CHAN) begin
				due_replies.push_back(mk_rsp(cmt_pkg::ST_FULL, '0, 1'b0, '0, 1'b1));
			end else begin
				src_pid[open_cnt] = r.pid;
				dst_pid[open_cnt] = r.peer_pid;
				waiting[open_cnt] = 1'b0;
				due_replies.push_back(mk_rsp(cmt_pkg::ST_OK,
					10'(cmt_pkg::CHANNEL_BASE + open_cnt), 1'b0, '0, 1'b1));
				open_cnt++;
			end
		end else if (r.operation == cmt_pkg::OP_SEND_BEGIN) begin
			if (r.length > SLOT_SIZE)
				due_replies.push_back(mk_rsp(cmt_pkg::ST_TOO_LONG, '0, 1'b0, '0, 1'b1));
			else if (!r.rate_ok)
				due_replies.push_back(mk_rsp(cmt_pkg::ST_RATE, '0, 1'b0, '0, 1'b1));
			else if (idx < 0 || src_pid[idx] != r.pid)
				due_replies.push_back(mk_rsp(cmt_pkg::ST_NO_CHANNEL, '0, 1'b0, '0, 1'b1));
			else if (waiting[idx])
				due_replies.push_back(mk_rsp(cmt_pkg::ST_BUSY, '0, 1'b0, '0, 1'b1));
			else if (!r.access_ok)
				due_replies.push_back(mk_rsp(cmt_pkg::ST_ACCESS, '0, 1'b0, '0, 1'b1));
			else begin
				msg_len[idx] = 7'(r.length);
				if (r.length == 0) begin
					waiting[idx] = 1'b1;
				end else begin
					loading = 1'b1;
					load_ch = 4'(idx);
					load_left = 7'(r.length);
					load_pos = '0;
				end
				due_replies.push_back(mk_rsp(cmt_pkg::ST_OK, '0, 1'b0, '0, 1'b1));
			end
		end else begin
			if (idx < 0 || dst_pid[idx] != r.pid)
				due_replies.push_back(mk_rsp(cmt_pkg::ST_NO_CHANNEL, '0, 1'b0, '0, 1'b1));
			else if (!waiting[idx])
				due_replies.push_back(mk_rsp(cmt_pkg::ST_EMPTY, '0, 1'b0, '0, 1'b1));
			else if (!r.access_ok)
				due_replies.push_back(mk_rsp(cmt_pkg::ST_ACCESS, '0, 1'b0, '0, 1'b1));
			else begin
				n = (msg_len[idx] < r.length) ? int'(msg_len[idx]) : int'(r.length);
				waiting[idx] = 1'b0;
				if (n == 0)
					due_replies.push_back(mk_rsp(cmt_pkg::ST_OK, '0, 1'b0, '0, 1'b1));
				for (int i = 0; i < n; i++)
					due_replies.push_back(mk_rsp(cmt_pkg::ST_OK, '0, 1'b1,
						slot_bytes[idx][i], i == n - 1));
			end
		end
	endtask

	// driver: holds each item until taken, then idles for a drawn number of cycles
	always @(negedge clk) begin : drive
		logic go;
		go = start;
		if (arst_n && (!start || taken)) begin
			if (taken) begin
				if ($urandom_range(0, 39) == 0)
					burst = !burst;
				gap = burst ? 0 : $urandom_range(0, 7);
			end
			if (gap > 0) begin
				gap--;
				go = 1'b0;
			end else if (pending.size() > 0) begin
				cmd <= pending.pop_front();
				go = 1'b1;
			end else begin
				go = 1'b0;
			end
		end
		start <= go;
	end

	// monitor: checks each response, predicts on each accepted item
	always @(posedge clk) begin : watch
		cmt_pkg::rsp_t want;
		if (!arst_n) begin
			taken <= 1'b0;
		end else begin
			if (resp_valid) begin
				if (due_replies.size() == 0) begin
					errors++;
					$display("%0t: expected no response, got %0d/%0d/%b/%h/%b",
						$time, resp.status, resp.channel_out, resp.data_valid,
						resp.data_out, resp.last);
				end else begin
					want = due_replies.pop_front();
					n_replies++;
					if (want.data_valid)
						n_bytes++;
					if (resp.status !== want.status || resp.channel_out !== want.channel_out ||
							resp.data_valid !== want.data_valid ||
							resp.data_out !== want.data_out || resp.last !== want.last) begin
						errors++;
						$display("%0t: expected %0d/%0d/%b/%h/%b, got %0d/%0d/%b/%h/%b",
							$time, want.status, want.channel_out, want.data_valid,
							want.data_out, want.last, resp.status, resp.channel_out,
							resp.data_valid, resp.data_out, resp.last);
					end
				end
			end
			if (start && !busy) begin
				compute_replies(cmd);
				n_accepted <= n_accepted + 1;
				taken <= 1'b1;
			end else begin
				taken <= 1'b0;
			end
		end
	end

	task automatic add(input logic [1:0] op, input logic [31:0] ch, input logic [31:0] pid,
			input logic [31:0] dpid, input logic [15:0] len, input logic rate,
			input logic acc, input logic [7:0] b);
		cmt_pkg::req_t r;
		r.operation = op;
		r.chan_ref = ch;
		r.pid = pid;
		r.peer_pid = dpid;
		r.length = len;
		r.rate_ok = rate;
		r.access_ok = acc;
		r.data_byte = b;
		pending.push_back(r);
		n_issued++;
	endtask

	// a command other than a data byte with random fields; refused while loading
	task automatic add_lock_probe();
		logic [1:0] op;
		case ($urandom_range(0, 2))
			0: op = cmt_pkg::OP_OPEN;
			1: op = cmt_pkg::OP_SEND_BEGIN;
			default: op = cmt_pkg::OP_RECEIVE;
		endcase
		add(op, cmt_pkg::CHANNEL_BASE + $urandom_range(0, NUM_CHAN - 1), $urandom, $urandom,
			16'($urandom_range(0, SLOT_SIZE)), 1'b1, 1'b1, 8'($urandom));
	endtask

	task automatic gen_sequence(input logic [31:0] pid_pool [8]);
		int idx;
		int pick;
		int fault;
		logic [31:0] ch;
		logic [31:0] pid;
		logic [15:0] len;
		logic rate;
		logic acc;
		pick = $urandom_range(0, 99);
		idx = (open_cnt == 0) ? 0 : $urandom_range(0, open_cnt - 1);
		fault = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : 0;
		rate = 1'b1;
		acc = 1'b1;
		if (loading) begin
			if ($urandom_range(0, 3) == 0)
				add_lock_probe();
			else
				for (int k = 0; k < load_left; k++)
					add(cmt_pkg::OP_SEND_DATA, $urandom, $urandom, $urandom, 16'($urandom),
						1'($urandom), 1'($urandom), 8'($urandom));
		end else if (pick < 12 || open_cnt == 0) begin
			add(cmt_pkg::OP_OPEN, $urandom, pid_pool[$urandom_range(0, 7)],
				pid_pool[$urandom_range(0, 7)], 16'($urandom), 1'($urandom), 1'($urandom),
				8'($urandom));
		end else if (pick < 55 && !(waiting[idx] && $urandom_range(0, 3) != 0)) begin
			ch = cmt_pkg::CHANNEL_BASE + idx;
			pid = src_pid[idx];
			pick = $urandom_range(0, 9);
			len = (pick < 6) ? 16'($urandom_range(0, 8)) :
				(pick < 8) ? 16'(SLOT_SIZE) : 16'($urandom_range(0, SLOT_SIZE));
			case (fault)
				1: len = 16'($urandom_range(SLOT_SIZE + 1, 65535));
				2: rate = 1'b0;
				3: pid = pid ^ (32'd1 << $urandom_range(0, 31));
				4: ch = $urandom_range(0, 1) ? cmt_pkg::CHANNEL_BASE + open_cnt : $urandom;
				5: acc = 1'b0;
				default: ;
			endcase
			add(cmt_pkg::OP_SEND_BEGIN, ch, pid, $urandom, len, rate, acc, 8'($urandom));
			if (fault == 0 && !waiting[idx])
				for (int k = 0; k < len; k++) begin
					if ($urandom_range(0, 9) == 0)
						add_lock_probe();
					if (k > 0 && $urandom_range(0, 39) == 0)
						break;
					add(cmt_pkg::OP_SEND_DATA, $urandom, $urandom, $urandom, 16'($urandom),
						1'($urandom), 1'($urandom), 8'($urandom));
				end
		end else if (pick < 85) begin
			ch = cmt_pkg::CHANNEL_BASE + idx;
			pid = dst_pid[idx];
			if ($urandom_range(0, 2) == 0)
				len = 16'($urandom_range(0, 8));
			else
				len = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 70));
			case (fault)
				1, 2: pid = pid ^ (32'd1 << $urandom_range(0, 31));
				3: ch = $urandom_range(0, 1) ? cmt_pkg::CHANNEL_BASE - 1 : $urandom;
				4, 5: acc = 1'b0;
				default: ;
			endcase
			add(cmt_pkg::OP_RECEIVE, ch, pid, $urandom, len, 1'($urandom), acc, 8'($urandom));
		end else begin
			ch = ($urandom_range(0, 3) == 0) ?
				cmt_pkg::CHANNEL_BASE + $urandom_range(0, NUM_CHAN + 1) : $urandom;
			add(2'($urandom_range(0, 3)), ch, $urandom, $urandom, 16'($urandom),
				1'($urandom), 1'($urandom), 8'($urandom));
		end
	endtask

	initial begin : stimulus
		logic [31:0] pa;
		logic [31:0] pb;
		logic [31:0] pid_pool [8];
		int n_directed;
		pa = '1;
		pb = '0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		add(cmt_pkg::OP_SEND_DATA, 0, 0, 0, 0, 1'b0, 1'b0, 8'h3C);
		add(cmt_pkg::OP_RECEIVE, 0, pb, 0, 16'd1, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_SEND_BEGIN, 0, pa, 0, 16'hFFFF, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_OPEN, 0, pa, pb, 0, 1'b0, 1'b0, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pa, 0, 16'(SLOT_SIZE + 1),
			1'b1, 1'b1, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pa, 0, 16'(SLOT_SIZE),
			1'b0, 1'b1, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE - 1, pa, 0, 16'(SLOT_SIZE),
			1'b1, 1'b1, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pb, 0, 16'd1, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pa, 0, 16'd1, 1'b1, 1'b0, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pa, 0, 16'd3, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_OPEN, 0, pb, pa, 0, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_RECEIVE, cmt_pkg::CHANNEL_BASE, pb, 0, 16'd3, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pa, 0, 16'd2, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_SEND_DATA, 0, 0, 0, 0, 1'b0, 1'b0, 8'h00);
		add(cmt_pkg::OP_SEND_DATA, 0, 0, 0, 0, 1'b0, 1'b0, 8'hFF);
		add(cmt_pkg::OP_SEND_DATA, 0, 0, 0, 0, 1'b0, 1'b0, 8'h5A);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pa, 0, 16'd2, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_RECEIVE, cmt_pkg::CHANNEL_BASE, pa, 0, 16'd3, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_RECEIVE, cmt_pkg::CHANNEL_BASE + 1, pb, 0, 16'd3, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_RECEIVE, cmt_pkg::CHANNEL_BASE, pb, 0, 16'd3, 1'b1, 1'b0, 0);
		add(cmt_pkg::OP_RECEIVE, cmt_pkg::CHANNEL_BASE, pb, 0, 16'd2, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_RECEIVE, cmt_pkg::CHANNEL_BASE, pb, 0, 16'd2, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_SEND_BEGIN, cmt_pkg::CHANNEL_BASE, pa, 0, 16'd0, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_RECEIVE, cmt_pkg::CHANNEL_BASE, pb, 0, 16'hFFFF, 1'b1, 1'b1, 0);
		add(cmt_pkg::OP_RECEIVE, 32'hFFFF_FFFF, pb, 0, 16'd1, 1'b1, 1'b1, 0);
		n_directed = n_issued;

		for (int i = 0; i < 8; i++)
			pid_pool[i] = $urandom;
		while (n_issued < n_directed + N_RANDOM) begin
			wait (n_accepted == n_issued);
			gen_sequence(pid_pool);
		end

		wait (n_accepted == n_issued);
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("Ran %0d commands (%0d directed), checked %0d responses,", n_accepted,
			n_directed, n_replies);
		$display("  %0d payload bytes received, %0d of %0d channels opened.", n_bytes,
			open_cnt, NUM_CHAN);
		if (errors == 0)
			$display("channel_mailbox_table_test passed");
		else
			$display("channel_mailbox_table_test failed");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Timed out with %0d responses outstanding", due_replies.size());
		$display("channel_mailbox_table_test failed");
		$finish;
	end

endmodule
